### src/tdp_pkg.sv
// Shared types for the trial-division prime tester.
// Holds the sequencer state encoding and the remainder unit status bundle.
// No dependencies.
package tdp_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } tdp_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tdp_rem_status_t;

  localparam int unsigned FIRST_DIVISOR = 2;

endpackage

### src/trial_division_prime_test.sv
// Top level of the trial-division prime tester.
// Depends on tdp_pkg and the serial remainder unit tdp_rem.
//
// An item is taken at a rising edge with start high and busy low: in_candidate
// is the number to test and in_last_in a flag that is returned unchanged.
// Busy stays high until the result has been produced. The result appears on
// out_prime_value, out_is_prime and out_last_out for exactly one cycle while
// out_valid is high; the receiver has no way to hold it off.
// Divisors 2, 3, 4, ... are tried while divisor squared does not exceed the
// candidate, and the test stops at the first one that divides it. Each trial
// runs the shared bit-serial remainder unit over all VALUE_BITS dividend bits,
// framed by the test and divide steps of the sequencer; at 20 bits the worst
// case is 1022 trial divisors. Zero, one, two and three finish without any
// trial division.
// A new item may be started in the cycle in which the result is shown.
// Reset clears the sequencer and the result strobe; nothing else is kept.
module trial_division_prime_test #(
  parameter int VALUE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_candidate,
  input  logic                  in_last_in,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_prime_value,
  output logic                  out_is_prime,
  output logic                  out_last_out
);
  import tdp_pkg::*;

  localparam int Y_W  = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W = VALUE_BITS + 1;

  tdp_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic                  last_r, last_nxt;
  logic [Y_W-1:0]        y_r, y_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic                  prime_r, prime_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                  out_prime_r, out_prime_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  div_start;
  logic [Y_W-1:0]        rem;
  tdp_rem_status_t       div_st;

  tdp_rem #(
    .DIVIDEND_BITS(VALUE_BITS),
    .DIVISOR_BITS (Y_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cand_r),
    .divisor  (y_r),
    .remainder(rem),
    .status   (div_st)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    last_nxt      = last_r;
    y_nxt         = y_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_prime_nxt = out_prime_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cand_nxt  = in_candidate;
          last_nxt  = in_last_in;
          y_nxt     = Y_W'(FIRST_DIVISOR);
          sq_nxt    = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (cand_r < VALUE_BITS'(FIRST_DIVISOR)) begin
          prime_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (sq_r > {1'b0, cand_r}) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (rem == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            y_nxt     = y_r + 1'b1;
            sq_nxt    = sq_r + SQ_W'({y_r, 1'b1});
            state_nxt = S_TEST;
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = cand_r;
        out_prime_nxt = prime_r;
        out_last_nxt  = last_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    last_r      <= last_nxt;
    y_r         <= y_nxt;
    sq_r        <= sq_nxt;
    prime_r     <= prime_nxt;
    out_value_r <= out_value_nxt;
    out_prime_r <= out_prime_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_is_prime    = out_prime_r;
  assign out_last_out    = out_last_r;

  a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_DONE)
    else $error("result strobe without a finished item");

  a_accept_starts_test: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_TEST)
    else $error("accepted item did not start a test");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("remainder finished outside the divide step");

  a_prime_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> out_value_r >= VALUE_BITS'(FIRST_DIVISOR))
    else $error("value below two reported as prime");

endmodule

### src/tdp_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on tdp_pkg for the status bundle.
module tdp_rem #(
  parameter int DIVIDEND_BITS = 20,
  parameter int DIVISOR_BITS  = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DIVIDEND_BITS-1:0]      dividend,
  input  logic [DIVISOR_BITS-1:0]       divisor,
  output logic [DIVISOR_BITS-1:0]       remainder,
  output tdp_pkg::tdp_rem_status_t      status
);
  import tdp_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] shift_r, shift_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;

  assign trial = {rem_r, shift_r[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
      cnt_nxt   = CNT_W'(DIVIDEND_BITS);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = shift_r << 1;
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[DIVISOR_BITS-1:0];
      end else begin
        rem_nxt = trial[DIVISOR_BITS-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

### test/trial_division_prime_test_tb.sv
// Self-checking testbench for the trial-division prime tester.
// It depends on tdp_pkg and trial_division_prime_test and reads no files.
// A directed list and then biased random candidates are checked against a primality predictor.
module trial_division_prime_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdp_pkg::*;

  localparam int VB = 20;

  typedef struct {
    logic [VB-1:0] candidate;
    logic          last;
  } candidate_item_t;

  typedef struct {
    logic [VB-1:0] value;
    logic          prime;
    logic          last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [VB-1:0] in_candidate;
  logic in_last_in;
  logic out_valid;
  logic [VB-1:0] out_prime_value;
  logic out_is_prime;
  logic out_last_out;

  candidate_item_t candidates_to_send[$];
  verdict_t awaited_verdicts[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned failures = 0;
  int unsigned sender_idle_pct = 0;
  logic taken;

  trial_division_prime_test #(.VALUE_BITS(VB)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_candidate(in_candidate),
    .in_last_in(in_last_in),
    .out_valid(out_valid),
    .out_prime_value(out_prime_value),
    .out_is_prime(out_is_prime),
    .out_last_out(out_last_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic primality_of(logic [VB-1:0] value);
    longint unsigned x;
    longint unsigned d;
    x = value;
    if (x < FIRST_DIVISOR) return 1'b0;
    for (d = FIRST_DIVISOR; d * d <= x; d++) begin
      if (x % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [VB-1:0] pick_candidate();
    int unsigned root;
    int unsigned kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3, 4: begin
        return VB'($urandom_range(4095));
      end
      5, 6: begin
        return VB'($urandom_range(65535));
      end
      7: begin
        return VB'($urandom);
      end
      8: begin
        root = $urandom_range(63);
        return VB'(root * root + $urandom_range(2) - 1);
      end
      default: begin
        root = $urandom_range(1023, 2);
        return VB'(root * root + $urandom_range(2) - 1);
      end
    endcase
  endfunction

  task automatic queue_candidate(logic [VB-1:0] value, logic last);
    candidate_item_t item;
    item.candidate = value;
    item.last = last;
    candidates_to_send = {candidates_to_send, item};
    queued_total++;
  endtask

  task automatic wait_for_drain();
    while (accepted_total != queued_total || awaited_verdicts.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    candidate_item_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
    end else if (candidates_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      item = candidates_to_send.pop_front();
      start <= 1'b1;
      in_candidate <= item.candidate;
      in_last_in <= item.last;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        want.value = in_candidate;
        want.prime = primality_of(in_candidate);
        want.last = in_last_in;
        awaited_verdicts = {awaited_verdicts, want};
        accepted_total++;
      end
      if (out_valid) begin
        if (awaited_verdicts.size() == 0) begin
          $error("unexpected result: value %0d", out_prime_value);
          failures++;
        end else begin
          want = awaited_verdicts.pop_front();
          if (out_prime_value !== want.value) begin
            $error("prime_value: expected %0d, got %0d", want.value, out_prime_value);
            failures++;
          end
          if (out_is_prime !== want.prime) begin
            $error("is_prime: expected %0d, got %0d (value %0d)", want.prime, out_is_prime,
                   want.value);
            failures++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, out_last_out);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned idle_by_phase[3];
    logic [VB-1:0] directed[$];
    idle_by_phase = '{26, 47, 0};
    directed = {20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7, 20'd8, 20'd9,
                20'd25, 20'd49, 20'd121, 20'd143, 20'd1048575, 20'd1048573, 20'd1042441,
                20'd1046527, 20'd524288, 20'd349525, 20'd699050, 20'd65537, 20'd1021};
    rst_n = 1'b0;
    start = 1'b0;
    in_candidate = '0;
    in_last_in = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      if (phase == 0) begin
        foreach (directed[i]) queue_candidate(directed[i], i[0]);
      end
      for (int n = 0; n < 26; n++) queue_candidate(pick_candidate(), 1'($urandom));
      @(negedge clk);
      wait_for_drain();
    end
    repeat (40) @(negedge clk);
    if (failures == 0 && awaited_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
